FILE: hw/rtl/sbs_pkg.sv
// shared types, constants and arithmetic helpers for the spectrum band sum block
package sbs_pkg;

    // frame and band geometry
    localparam int NUM_BINS    = 64;
    localparam int NUM_BANDS   = 6;
    localparam int BIN_W       = $clog2(NUM_BINS);
    localparam int BAND_W      = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int BYTE_COUNT  = 6;

    // field widths
    localparam int VAL_W       = 8;
    localparam int WGT_W       = 9;
    localparam int WGT_FRAC    = 8;
    localparam int WGT_ONE     = 256;
    localparam int RANGE_W     = 48;
    localparam int SUM_W       = 14;
    localparam int IDX_W       = 6;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 48;
    localparam logic [VAL_W-1:0]   THRESHOLD_RST = 8'd8;
    localparam logic [WGT_W-1:0]   WEIGHT_RST    = 9'd230;
    localparam logic [RANGE_W-1:0] LOWS_RST      = 48'd36357049484033;
    localparam logic [RANGE_W-1:0] HIGHS_RST     = 48'd69406940464130;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_PAD_W   = 6;
    localparam int OUT_TDATA_W = IDX_W + 2 * SUM_W + OUT_PAD_W;

    // work queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WEIGHT    = 2'd1,
        CFG_LOWS      = 2'd2,
        CFG_HIGHS     = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        KIND_BIN  = 1'b0,
        KIND_BAND = 1'b1
    } t_kind;

    // one classified bin waiting for the back end
    typedef struct packed {
        logic [VAL_W-1:0]     value;
        logic [BIN_W-1:0]     bin;
        logic                 last;
        logic [NUM_BANDS-1:0] hits;
    } t_work;

    // one result item
    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] idx;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] smooth;
        logic             done;
    } t_result;

    // byte k of a packed band edge word, zero beyond the stored bytes
    function automatic logic [VAL_W-1:0] band_byte(input logic [RANGE_W-1:0] edges,
                                                   input int k);
        logic [RANGE_W-1:0] shifted;
        shifted = edges >> (VAL_W * k);
        if (k >= BYTE_COUNT) begin
            return '0;
        end
        return shifted[VAL_W-1:0];
    endfunction

    // (old*w + x*(1-w)) >> 8 written as (x<<8 + (old-x)*w) >> 8, one multiplier
    function automatic logic [SUM_W-1:0] smooth(input logic [SUM_W-1:0] old_v,
                                                input logic [SUM_W-1:0] new_v,
                                                input logic [WGT_W-1:0] w);
        logic signed [SUM_W:0]               diff;
        logic signed [SUM_W+WGT_W+1:0]       prod;
        logic signed [SUM_W+WGT_W+2:0]       total;
        diff  = $signed({1'b0, old_v}) - $signed({1'b0, new_v});
        prod  = diff * $signed({1'b0, w});
        total = $signed({4'b0, new_v, {WGT_FRAC{1'b0}}}) + $signed({prod[SUM_W+WGT_W+1], prod});
        return total[WGT_FRAC +: SUM_W];
    endfunction

endpackage

FILE: hw/rtl/sbs_front.sv
// front end: accepts bins, counts the bin index and works out band membership
module sbs_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    output logic                              o_rdy,
    input  logic [sbs_pkg::VAL_W-1:0]         i_value,
    input  logic [sbs_pkg::VAL_W-1:0]         i_threshold,
    input  logic [sbs_pkg::RANGE_W-1:0]       i_lows,
    input  logic [sbs_pkg::RANGE_W-1:0]       i_highs,
    input  logic                              i_q_full,
    output logic                              o_push,
    output sbs_pkg::t_work                    o_work
);

    logic [sbs_pkg::BIN_W-1:0]     r_bin_cnt;
    logic [sbs_pkg::BIN_W-1:0]     n_bin_cnt;
    logic                          last_bin;
    logic                          above;
    logic [sbs_pkg::VAL_W-1:0]     bin_byte;
    logic [sbs_pkg::NUM_BANDS-1:0] hits;

    // handshake: take a request whenever the queue has room
    assign o_rdy  = !i_q_full;
    assign o_push = i_vld && !i_q_full;

    // bin counter, wraps at the end of a frame
    assign last_bin  = (r_bin_cnt == sbs_pkg::BIN_W'(sbs_pkg::NUM_BINS - 1));
    assign n_bin_cnt = last_bin ? '0 : r_bin_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt <= '0;
        end else if (o_push) begin
            r_bin_cnt <= n_bin_cnt;
        end
    end

    // band membership, already gated by the threshold
    assign bin_byte = sbs_pkg::VAL_W'(r_bin_cnt);
    assign above    = (i_value > i_threshold);

    always_comb begin
        for (int k = 0; k < sbs_pkg::NUM_BANDS; k++) begin
            hits[k] = above
                   && (bin_byte >= sbs_pkg::band_byte(i_lows, k))
                   && (bin_byte <= sbs_pkg::band_byte(i_highs, k));
        end
    end

    // work item for the back end
    always_comb begin
        o_work.value = i_value;
        o_work.bin   = r_bin_cnt;
        o_work.last  = last_bin;
        o_work.hits  = hits;
    end

endmodule

FILE: hw/rtl/sbs_queue.sv
// short work queue that decouples the front end from the back end
module sbs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sbs_pkg::t_work i_work,
    output logic           o_full,
    output logic           o_vld,
    output sbs_pkg::t_work o_work,
    input  logic           i_pop
);

    sbs_pkg::t_work               r_q [sbs_pkg::QUEUE_DEPTH];
    logic [sbs_pkg::QPTR_W-1:0]   r_wr;
    logic [sbs_pkg::QPTR_W-1:0]   r_rd;
    logic [sbs_pkg::QCNT_W-1:0]   r_cnt;
    logic                         do_pop;

    assign o_full = (r_cnt == sbs_pkg::QCNT_W'(sbs_pkg::QUEUE_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_work = r_q[r_rd];
    assign do_pop = i_pop && o_vld;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_work;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/sbs_back.sv
// back end: bin average memory, band sums, band burst sequencer and result register
module sbs_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_vld,
    input  sbs_pkg::t_work            i_q_work,
    output logic                      o_q_pop,
    input  logic [sbs_pkg::WGT_W-1:0] i_weight,
    output logic                      o_res_vld,
    output sbs_pkg::t_result          o_res,
    input  logic                      i_res_rdy
);

    // bin average memory with one valid bit per entry
    logic [sbs_pkg::VAL_W-1:0]     r_mem [sbs_pkg::NUM_BINS];
    logic [sbs_pkg::NUM_BINS-1:0]  r_mem_vld;
    logic [sbs_pkg::VAL_W-1:0]     r_rd_data;
    logic                          r_rd_hit;

    // item being executed
    logic                          r_a_vld;
    sbs_pkg::t_work                r_a;

    // band state and burst sequencer
    logic [sbs_pkg::SUM_W-1:0]     r_sum  [sbs_pkg::NUM_BANDS];
    logic [sbs_pkg::SUM_W-1:0]     r_bavg [sbs_pkg::NUM_BANDS];
    logic [sbs_pkg::SUM_W-1:0]     n_sum  [sbs_pkg::NUM_BANDS];
    logic                          r_band_active;
    logic [sbs_pkg::BAND_W-1:0]    r_band_k;
    logic                          band_last;

    // result register
    logic                          r_o_vld;
    sbs_pkg::t_result              r_o;
    sbs_pkg::t_result              n_o;

    logic                          out_free;
    logic                          band_fire;
    logic                          a_consume;
    logic                          a_load;
    logic [sbs_pkg::WGT_W-1:0]     w_sat;
    logic [sbs_pkg::VAL_W-1:0]     old_bin;
    logic [sbs_pkg::SUM_W-1:0]     sm_old;
    logic [sbs_pkg::SUM_W-1:0]     sm_new;
    logic [sbs_pkg::SUM_W-1:0]     sm;

    // flow control
    assign out_free  = !r_o_vld || i_res_rdy;
    assign band_fire = r_band_active && out_free;
    assign a_consume = !r_band_active && r_a_vld && out_free;
    assign a_load    = i_q_vld && (!r_a_vld || a_consume);
    assign o_q_pop   = a_load;
    assign band_last = (r_band_k == sbs_pkg::BAND_W'(sbs_pkg::NUM_BANDS - 1));

    // weight saturated to one
    assign w_sat = (i_weight > sbs_pkg::WGT_W'(sbs_pkg::WGT_ONE))
                 ? sbs_pkg::WGT_W'(sbs_pkg::WGT_ONE) : i_weight;

    // shared smoothing unit, band burst has priority
    assign old_bin = r_rd_hit ? r_rd_data : '0;
    assign sm_old  = r_band_active ? r_bavg[r_band_k] : sbs_pkg::SUM_W'(old_bin);
    assign sm_new  = r_band_active ? r_sum[r_band_k]  : sbs_pkg::SUM_W'(r_a.value);
    assign sm      = sbs_pkg::smooth(sm_old, sm_new, w_sat);

    // execution slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_load) begin
            r_a_vld <= 1'b1;
        end else if (a_consume) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a <= i_q_work;
        end
    end

    // bin average memory: read as an item enters, write back as it leaves
    always_ff @(posedge i_clk) begin
        if (a_consume) begin
            r_mem[r_a.bin] <= sm[sbs_pkg::VAL_W-1:0];
        end
        if (a_load) begin
            r_rd_data <= r_mem[i_q_work.bin];
            r_rd_hit  <= r_mem_vld[i_q_work.bin];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (a_consume) begin
            r_mem_vld[r_a.bin] <= 1'b1;
        end
    end

    // saturating band sum update
    always_comb begin
        for (int k = 0; k < sbs_pkg::NUM_BANDS; k++) begin
            if ({1'b0, r_sum[k]} + (sbs_pkg::SUM_W + 1)'(r_a.value)
                    > {1'b0, sbs_pkg::SUM_MAX}) begin
                n_sum[k] = sbs_pkg::SUM_MAX;
            end else begin
                n_sum[k] = r_sum[k] + sbs_pkg::SUM_W'(r_a.value);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < sbs_pkg::NUM_BANDS; k++) begin
                r_sum[k]  <= '0;
                r_bavg[k] <= '0;
            end
        end else if (band_fire) begin
            r_sum[r_band_k]  <= '0;
            r_bavg[r_band_k] <= sm;
        end else if (a_consume) begin
            for (int k = 0; k < sbs_pkg::NUM_BANDS; k++) begin
                if (r_a.hits[k]) begin
                    r_sum[k] <= n_sum[k];
                end
            end
        end
    end

    // band burst after the last bin of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_active <= 1'b0;
            r_band_k      <= '0;
        end else if (a_consume && r_a.last) begin
            r_band_active <= 1'b1;
            r_band_k      <= '0;
        end else if (band_fire) begin
            if (band_last) begin
                r_band_active <= 1'b0;
            end else begin
                r_band_k <= r_band_k + 1'b1;
            end
        end
    end

    // next result
    always_comb begin
        if (r_band_active) begin
            n_o.kind   = sbs_pkg::KIND_BAND;
            n_o.idx    = sbs_pkg::IDX_W'(r_band_k);
            n_o.sum    = r_sum[r_band_k];
            n_o.smooth = sm;
            n_o.done   = band_last;
        end else begin
            n_o.kind   = sbs_pkg::KIND_BIN;
            n_o.idx    = sbs_pkg::IDX_W'(r_a.bin);
            n_o.sum    = '0;
            n_o.smooth = sbs_pkg::SUM_W'(sm[sbs_pkg::VAL_W-1:0]);
            n_o.done   = 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (band_fire || a_consume) begin
            r_o_vld <= 1'b1;
        end else if (i_res_rdy) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (band_fire || a_consume) begin
            r_o <= n_o;
        end
    end

    assign o_res_vld = r_o_vld;
    assign o_res     = r_o;

`ifndef ASSERT_OFF
    // end of frame is only ever flagged on a band result
    a_done_on_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o.done) |-> (r_o.kind == sbs_pkg::KIND_BAND))
        else $error("frame end flagged on a bin result");

    // the last bin of a frame always starts a band burst from band zero
    a_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_consume && r_a.last) |=> (r_band_active && (r_band_k == '0)))
        else $error("band burst did not start after the last bin");

    // the burst counter stays inside the band range
    a_burst_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_band_active |-> (r_band_k <= sbs_pkg::BAND_W'(sbs_pkg::NUM_BANDS - 1)))
        else $error("band counter out of range");

    // the burst ends right after the last band
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (band_fire && band_last) |=> !r_band_active)
        else $error("band burst did not end after the last band");
`endif

endmodule

FILE: hw/rtl/spectrum_band_sum_and_smoothing.sv
// top level: configuration registers, stream ports and the front, queue and back ends
//
// Takes one 8-bit spectrum bin per cycle and returns, for each bin, its
// updated exponential average; after the last of the NUM_BINS bins of a frame
// it also returns one result per band (NUM_BANDS of them) with the frame's
// thresholded band sum and the band's updated average, the last of these with
// tlast set. Input requests are taken one per cycle while the four-entry work
// queue has room; results leave at most one per cycle from the output
// register. The single shared smoothing multiplier serves both bin and band
// results. A result passes from the work queue through the execution slot and
// the result register after its bin is taken. Bin averages live in a memory
// whose entries read as zero until first written; no start-up sweep is needed.
// Configuration writes take effect at once and are meant for idle periods.
module spectrum_band_sum_and_smoothing (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [sbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sbs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // bin input: tdata [7:0] bin_value
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sbs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // results: tdata [5:0] result_index, [19:6] band_sum, [33:20] smoothed_value, [39:34] zero
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sbs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tuser [0] result_kind
    output logic [0:0]                        m_axis_tuser,
    // tlast frame_done
    output logic                              m_axis_tlast
);

    logic [sbs_pkg::VAL_W-1:0]   r_threshold;
    logic [sbs_pkg::WGT_W-1:0]   r_weight;
    logic [sbs_pkg::RANGE_W-1:0] r_lows;
    logic [sbs_pkg::RANGE_W-1:0] r_highs;

    logic                        push;
    logic                        q_full;
    logic                        q_vld;
    logic                        q_pop;
    sbs_pkg::t_work              push_work;
    sbs_pkg::t_work              q_work;
    sbs_pkg::t_result            res;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= sbs_pkg::THRESHOLD_RST;
            r_weight    <= sbs_pkg::WEIGHT_RST;
            r_lows      <= sbs_pkg::LOWS_RST;
            r_highs     <= sbs_pkg::HIGHS_RST;
        end else if (i_cfg_we) begin
            unique case (sbs_pkg::t_cfg_idx'(i_cfg_idx))
                sbs_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[sbs_pkg::VAL_W-1:0];
                sbs_pkg::CFG_WEIGHT:    r_weight    <= i_cfg_data[sbs_pkg::WGT_W-1:0];
                sbs_pkg::CFG_LOWS:      r_lows      <= i_cfg_data[sbs_pkg::RANGE_W-1:0];
                sbs_pkg::CFG_HIGHS:     r_highs     <= i_cfg_data[sbs_pkg::RANGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front end
    sbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (s_axis_tvalid),
        .o_rdy       (s_axis_tready),
        .i_value     (s_axis_tdata[sbs_pkg::VAL_W-1:0]),
        .i_threshold (r_threshold),
        .i_lows      (r_lows),
        .i_highs     (r_highs),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_work      (push_work)
    );

    // work queue
    sbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_work  (q_work),
        .i_pop   (q_pop)
    );

    // back end
    sbs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_vld   (q_vld),
        .i_q_work  (q_work),
        .o_q_pop   (q_pop),
        .i_weight  (r_weight),
        .o_res_vld (m_axis_tvalid),
        .o_res     (res),
        .i_res_rdy (m_axis_tready)
    );

    // result packing
    assign m_axis_tdata = {{sbs_pkg::OUT_PAD_W{1'b0}}, res.smooth, res.sum, res.idx};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.done;

endmodule
